### design/dcf77_decoder_with_calendar_clock_unit_assert.svh
// Assertion macros for the DCF77 decoder block.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef DCF77_DECODER_WITH_CALENDAR_CLOCK_UNIT_ASSERT_SVH
`define DCF77_DECODER_WITH_CALENDAR_CLOCK_UNIT_ASSERT_SVH

// Checked only while out of reset.
`define DCFCAL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define DCFCAL_ASSERT_ARST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### design/dcfcal_pkg.sv
// Shared types and constants for the DCF77 decoder block.
// No dependencies.
`default_nettype none

package dcfcal_pkg;

  localparam int unsigned RunCountWidthDef = 8;
  localparam int unsigned CfgWidth         = 8;
  // Frame bits 0..58 are stored; bit 58 closes the frame.
  localparam int unsigned FrameLast        = 58;
  localparam int unsigned FrameBits        = FrameLast + 1;

  // Register reset values
  localparam logic [CfgWidth-1:0] RstTicksPerSec = 8'd100;
  localparam logic [CfgWidth-1:0] RstMarkerTicks = 8'd100;
  localparam logic [CfgWidth-1:0] RstZeroLowMin  = 8'd7;
  localparam logic [CfgWidth-1:0] RstOneLowMin   = 8'd13;

  typedef enum logic [1:0] {
    CfgTicksPerSec = 2'd0,
    CfgMarkerTicks = 2'd1,
    CfgZeroLowMin  = 2'd2,
    CfgOneLowMin   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    cfg_reg_e              reg_index;
    logic [CfgWidth-1:0]   wdata;
  } cfg_beat_t;

  typedef struct packed {
    logic signal_level;
  } in_beat_t;

  typedef struct packed {
    logic       second_mark;
    logic       in_sync;
    logic       frame_done;
    logic       frame_valid;
    logic [5:0] seconds;
    logic [5:0] minutes;
    logic [4:0] hours;
    logic [4:0] day_of_month;
    logic [3:0] month_num;
    logic [7:0] year_num;
    logic [2:0] weekday_num;
  } result_t;

  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hour;
    logic [4:0] day;
    logic [3:0] month;
    logic [7:0] year;
    logic [2:0] wday;
  } clock_t;

  localparam clock_t ClockReset = '{
    sec:   6'd0,
    min:   6'd59,
    hour:  5'd23,
    day:   5'd31,
    month: 4'd12,
    year:  8'd0,
    wday:  3'd1
  };

  // Days per month, no leap years; out-of-range months count as 31.
  function automatic logic [4:0] month_days(input logic [3:0] m);
    logic [4:0] d;
    case (m) inside
      4'd2:                    d = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
      default:                 d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

### design/dcfcal_stream_if.sv
// Valid/ready channel with a typed payload, used for all ports of the block.
// Payload types come from dcfcal_pkg.
`default_nettype none

interface dcfcal_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/dcfcal_frame_dec.sv
// Frame field decoder: weighted BCD sums, range checks, prefix merge.
// Depends on dcfcal_pkg.
`default_nettype none

module dcfcal_frame_dec (
  input  logic [dcfcal_pkg::FrameBits-1:0] frame_i,
  input  dcfcal_pkg::clock_t               base_i,
  output dcfcal_pkg::clock_t               clock_o,
  output logic                             valid_o
);

  // Weights 1,2,4,8,10,20,40,80: low nibble plus ten times high nibble
  function automatic logic [7:0] bcd_weigh(input logic [7:0] b);
    logic [7:0] tens;
    tens = {4'd0, b[7:4]};
    return {4'd0, b[3:0]} + (tens << 3) + (tens << 1);
  endfunction

  logic [7:0] min_v, hour_v, day_v, wday_v, month_v, year_v;
  logic       hour_ok, min_ok, day_ok, wday_ok, month_ok, year_ok;

  assign min_v   = bcd_weigh({1'b0, frame_i[27:21]});
  assign hour_v  = bcd_weigh({2'b0, frame_i[34:29]});
  assign day_v   = bcd_weigh({2'b0, frame_i[41:36]});
  assign wday_v  = bcd_weigh({5'b0, frame_i[44:42]});
  assign month_v = bcd_weigh({3'b0, frame_i[49:45]});
  assign year_v  = bcd_weigh(frame_i[57:50]);

  assign hour_ok  = hour_v <= 8'd23;
  assign min_ok   = min_v <= 8'd59;
  assign day_ok   = (day_v >= 8'd1) && (day_v <= 8'd31);
  assign wday_ok  = (wday_v >= 8'd1) && (wday_v <= 8'd7);
  assign month_ok = (month_v >= 8'd1) && (month_v <= 8'd12);
  assign year_ok  = year_v <= 8'd99;

  // Fields are loaded in check order, stopping at the first bad one
  always_comb begin
    clock_o     = base_i;
    clock_o.sec = '0;
    if (hour_ok) begin
      clock_o.hour = hour_v[4:0];
      if (min_ok) begin
        clock_o.min = min_v[5:0];
        if (day_ok) begin
          clock_o.day = day_v[4:0];
          if (wday_ok) begin
            clock_o.wday = wday_v[2:0];
            if (month_ok) begin
              clock_o.month = month_v[3:0];
              if (year_ok) begin
                clock_o.year = year_v;
              end
            end
          end
        end
      end
    end
  end

  assign valid_o = hour_ok && min_ok && day_ok && wday_ok && month_ok && year_ok;

endmodule

`default_nettype wire

### design/dcf77_decoder_with_calendar_clock_unit.sv
// DCF77 decoder top level: tick stage, second/bit logic, calendar, result register.
// Depends on dcfcal_pkg, dcfcal_stream_if and dcfcal_frame_dec.
// Each input beat passes the tick register, then the result register, before it is offered.
// Throughput: one input beat per cycle unless the output stalls; each tick is one
//   pass through the second/bit/calendar logic between the tick and result registers.
// Reset (rst_ni low, async): pipeline empties, clock loads 23:59 on 31.12.,
//   search mode, counters and the frame store cleared, registers to defaults.
`default_nettype none

module dcf77_decoder_with_calendar_clock_unit #(
  parameter int unsigned RUN_COUNT_WIDTH = dcfcal_pkg::RunCountWidthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  dcfcal_stream_if.sink   cfg_if,
  dcfcal_stream_if.sink   in_if,
  dcfcal_stream_if.source out_if
);

  // Run counters and 8-bit thresholds are compared at the wider of the two
  localparam int unsigned CmpW =
    (RUN_COUNT_WIDTH > dcfcal_pkg::CfgWidth) ? RUN_COUNT_WIDTH : dcfcal_pkg::CfgWidth;

  typedef logic [RUN_COUNT_WIDTH-1:0] run_t;
  typedef logic [CmpW-1:0]            cmp_t;

  // Rollover at the end of a local second: seconds carry into the calendar.
  function automatic dcfcal_pkg::clock_t roll_over(input dcfcal_pkg::clock_t c);
    dcfcal_pkg::clock_t r;
    r = c;
    if (c.sec > 6'd59) begin
      r.sec = '0;
      if (c.min >= 6'd59) begin
        r.min = '0;
        if (c.hour >= 5'd23) begin
          r.hour = '0;
          if (c.day >= dcfcal_pkg::month_days(c.month)) begin
            r.day = 5'd1;
            if (c.month >= 4'd12) begin
              r.month = 4'd1;
              r.year  = c.year + 8'd1;
            end else begin
              r.month = c.month + 4'd1;
            end
          end else begin
            r.day = c.day + 5'd1;
          end
          r.wday = (c.wday >= 3'd7) ? 3'd1 : c.wday + 3'd1;
        end else begin
          r.hour = c.hour + 5'd1;
        end
      end else begin
        r.min = c.min + 6'd1;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Configuration registers; writes are always taken
  // ---------------------------------------------------------------------
  logic [dcfcal_pkg::CfgWidth-1:0] tps_q, marker_q, zero_min_q, one_min_q;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q      <= dcfcal_pkg::RstTicksPerSec;
      marker_q   <= dcfcal_pkg::RstMarkerTicks;
      zero_min_q <= dcfcal_pkg::RstZeroLowMin;
      one_min_q  <= dcfcal_pkg::RstOneLowMin;
    end else if (cfg_if.valid) begin
      case (cfg_if.data.reg_index)
        dcfcal_pkg::CfgTicksPerSec: tps_q      <= cfg_if.data.wdata;
        dcfcal_pkg::CfgMarkerTicks: marker_q   <= cfg_if.data.wdata;
        dcfcal_pkg::CfgZeroLowMin:  zero_min_q <= cfg_if.data.wdata;
        dcfcal_pkg::CfgOneLowMin:   one_min_q  <= cfg_if.data.wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Handshake: tick register feeds the result register. The tick stage
  // refills when it is empty or the result register is free or being drained, so a
  // waiting result blocks the next input beat only while the tick stage is full.
  // ---------------------------------------------------------------------
  logic                s1_valid_q;
  logic                s1_level_q;
  logic                out_valid_q;
  dcfcal_pkg::result_t out_data_q, result;
  logic                out_free, s1_fire, in_take;

  assign out_free    = !out_valid_q || out_if.ready;
  assign s1_fire     = s1_valid_q && out_free;
  assign in_if.ready = !s1_valid_q || out_free;
  assign in_take     = in_if.valid && in_if.ready;

  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_data_q;

  // ---------------------------------------------------------------------
  // Decoder state
  // ---------------------------------------------------------------------
  logic [7:0]                       tick_q, tick_d;
  run_t                             high_run_q, high_run_d, low_run_q, low_run_d;
  run_t                             high_inc, low_inc;
  logic [5:0]                       bit_idx_q, bit_idx_d, bit_idx_inc;
  logic [dcfcal_pkg::FrameBits-1:0] bits_q, bits_d;
  logic                             sync_q, sync_d;
  dcfcal_pkg::clock_t               clock_q, clock_d, bumped, rolled, dec_clock;
  logic                             dec_valid;
  logic [8:0]                       tick_inc;
  logic                             mark, done;
  cmp_t                             low_cmp, high_cmp, zero_cmp, one_cmp, marker_cmp;

  // Run counting for this tick's level (saturating)
  always_comb begin
    high_inc = (high_run_q != '1) ? high_run_q + run_t'(1) : high_run_q;
    low_inc  = (low_run_q != '1) ? low_run_q + run_t'(1) : low_run_q;
    if (s1_level_q) begin
      high_run_d = high_inc;
      low_run_d  = sync_q ? low_run_q : '0;
    end else begin
      low_run_d  = low_inc;
      high_run_d = sync_q ? high_run_q : '0;
    end
  end

  assign tick_inc   = {1'b0, tick_q} + 9'd1;
  assign mark       = tick_inc >= {1'b0, tps_q};

  assign high_cmp   = CmpW'(high_run_d);
  assign low_cmp    = CmpW'(low_run_d);
  assign marker_cmp = CmpW'(marker_q);
  assign zero_cmp   = CmpW'(zero_min_q);
  assign one_cmp    = CmpW'(one_min_q);

  // Bit classification at a second boundary in sync mode; a short low
  // time leaves the stored bit alone.
  always_comb begin
    bits_d = bits_q;
    if (mark && sync_q && (bit_idx_q < 6'(dcfcal_pkg::FrameBits))) begin
      if ((low_cmp > zero_cmp) && (low_cmp <= one_cmp)) begin
        bits_d[bit_idx_q] = 1'b0;
      end else if (low_cmp > one_cmp) begin
        bits_d[bit_idx_q] = 1'b1;
      end
    end
  end

  // Clock with seconds advanced, and after the rollover
  always_comb begin
    bumped     = clock_q;
    bumped.sec = clock_q.sec + 6'd1;
  end
  assign rolled = roll_over(bumped);

  // Frame decode sees the store including the bit closed on this tick
  dcfcal_frame_dec u_frame_dec (
    .frame_i (bits_d),
    .base_i  (rolled),
    .clock_o (dec_clock),
    .valid_o (dec_valid)
  );

  assign bit_idx_inc = bit_idx_q + 6'd1;

  // Second boundary handling
  always_comb begin
    tick_d    = tick_inc[7:0];
    bit_idx_d = bit_idx_q;
    sync_d    = sync_q;
    clock_d   = clock_q;
    done      = 1'b0;
    if (mark) begin
      tick_d = '0;
      if (!sync_q) begin
        // Minute marker: enter sync, skip this second's rollover
        if (high_cmp > marker_cmp) begin
          bit_idx_d = '0;
          sync_d    = 1'b1;
          clock_d   = bumped;
        end else begin
          clock_d = rolled;
        end
      end else if (bit_idx_inc > 6'(dcfcal_pkg::FrameLast)) begin
        // Frame end: load checked fields, drop sync on any bad field
        bit_idx_d = '0;
        done      = 1'b1;
        clock_d   = dec_clock;
        sync_d    = dec_valid;
      end else begin
        bit_idx_d = bit_idx_inc;
        clock_d   = rolled;
      end
    end
  end

  always_comb begin
    result.second_mark  = mark;
    result.in_sync      = sync_d;
    result.frame_done   = done;
    result.frame_valid  = done && dec_valid;
    result.seconds      = clock_d.sec;
    result.minutes      = clock_d.min;
    result.hours        = clock_d.hour;
    result.day_of_month = clock_d.day;
    result.month_num    = clock_d.month;
    result.year_num     = clock_d.year;
    result.weekday_num  = clock_d.wday;
  end

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_level_q <= in_if.data.signal_level;
    end
    if (s1_fire) begin
      out_data_q <= result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q     <= '0;
      high_run_q <= '0;
      low_run_q  <= '0;
      bit_idx_q  <= '0;
      bits_q     <= '0;
      sync_q     <= 1'b0;
      clock_q    <= dcfcal_pkg::ClockReset;
    end else if (s1_fire) begin
      tick_q     <= tick_d;
      // Runs restart at every boundary except a plain search-mode second
      high_run_q <= (mark && (sync_q || (high_cmp > marker_cmp))) ? '0 : high_run_d;
      low_run_q  <= (mark && (sync_q || (high_cmp > marker_cmp))) ? '0 : low_run_d;
      bit_idx_q  <= bit_idx_d;
      bits_q     <= bits_d;
      sync_q     <= sync_d;
      clock_q    <= clock_d;
    end
  end

endmodule

`default_nettype wire

### design/dcfcal_checker.sv
// Port-level checks for the DCF77 decoder, bound to the top level.
// Depends on dcfcal_pkg and the assertion macro header.
`default_nettype none
`include "dcf77_decoder_with_calendar_clock_unit_assert.svh"

module dcfcal_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input dcfcal_pkg::result_t out_data_i
);

  // Result beat holds while stalled
  `DCFCAL_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i), "result beat changed while stalled")

  // No result beat right after reset
  `DCFCAL_ASSERT_ARST(a_rst_empty, !rst_ni |=> !out_valid_i, "result beat offered after reset")

  // A decoded frame clears seconds and keeps sync exactly when it was good
  `DCFCAL_ASSERT(a_frame_end, out_valid_i && out_data_i.frame_done |-> out_data_i.seconds == 6'd0 && out_data_i.in_sync == out_data_i.frame_valid, "frame end beat inconsistent")

  // Calendar fields stay in range
  `DCFCAL_ASSERT(a_cal_range, out_valid_i |-> out_data_i.minutes <= 6'd59 && out_data_i.hours <= 5'd23 && out_data_i.month_num >= 4'd1 && out_data_i.month_num <= 4'd12 && out_data_i.weekday_num >= 3'd1 && out_data_i.day_of_month >= 5'd1, "calendar field out of range")

endmodule

bind dcf77_decoder_with_calendar_clock_unit dcfcal_checker u_dcfcal_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_data_i  (out_if.data)
);

`default_nettype wire

### test/tb_top.sv
// Self-checking bench for the DCF77 decoder with calendar clock.
// Needs dcfcal_pkg, dcfcal_stream_if and dcf77_decoder_with_calendar_clock_unit.
`timescale 1ns / 100ps

module tb_top;
  import dcfcal_pkg::*;

  localparam int unsigned DaysInMonth [0:11] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  // Bit weights of a time field, LSB first (BCD units then tens).
  localparam int unsigned DigitWeight [0:7] = '{1, 2, 4, 8, 10, 20, 40, 80};
  localparam int unsigned RandomTicks = 1150;

  // Low-time class wanted for one second of stimulus.
  typedef enum int {
    BitZero,
    BitOne,
    BitKeep
  } sec_kind_e;

  logic clk_i;
  logic rst_ni;

  dcfcal_stream_if #(.T(cfg_beat_t)) cfg_ch ();
  dcfcal_stream_if #(.T(in_beat_t))  in_ch ();
  dcfcal_stream_if #(.T(result_t))   out_ch ();

  dcf77_decoder_with_calendar_clock_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_if (cfg_ch),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // ---------------------------------------------------------------------------
  // Decoder prediction: own copy of registers, run counters, frame store and
  // calendar. Advanced once per accepted input beat.
  // ---------------------------------------------------------------------------
  logic [CfgWidth-1:0]         cfg_tps, cfg_marker, cfg_zero_min, cfg_one_min;
  logic [7:0]                  tick_cnt;
  logic [RunCountWidthDef-1:0] low_run, high_run;
  logic [5:0]                  bit_idx;
  logic                        frame_bits [0:59];
  logic                        sync_on;
  int unsigned                 sec_r, min_r, hour_r, day_r, month_r, year_r, wday_r;

  result_t     tick_results_q [$];
  int unsigned ticks_sent;
  int unsigned err_cnt;
  // When set, neither side idles: back-to-back beats.
  bit          no_idle;

  function automatic void model_reset();
    cfg_tps      = RstTicksPerSec;
    cfg_marker   = RstMarkerTicks;
    cfg_zero_min = RstZeroLowMin;
    cfg_one_min  = RstOneLowMin;
    tick_cnt     = '0;
    low_run      = '0;
    high_run     = '0;
    bit_idx      = '0;
    foreach (frame_bits[i]) frame_bits[i] = 1'b0;
    sync_on      = 1'b0;
    sec_r        = ClockReset.sec;
    min_r        = ClockReset.min;
    hour_r       = ClockReset.hour;
    day_r        = ClockReset.day;
    month_r      = ClockReset.month;
    year_r       = ClockReset.year;
    wday_r       = ClockReset.wday;
  endfunction

  // Carry seconds up through the calendar. No leap years, year wraps at 256.
  function automatic void carry_calendar();
    int unsigned len;
    if (sec_r <= 59) return;
    sec_r = 0;
    min_r++;
    if (min_r <= 59) return;
    min_r = 0;
    hour_r++;
    if (hour_r <= 23) return;
    hour_r = 0;
    len = (month_r >= 1 && month_r <= 12) ? DaysInMonth[month_r - 1] : 31;
    day_r++;
    if (day_r > len) begin
      day_r = 1;
      month_r++;
      if (month_r > 12) begin
        month_r = 1;
        year_r  = (year_r + 1) & 8'hFF;
      end
    end
    wday_r++;
    if (wday_r > 7) wday_r = 1;
  endfunction

  function automatic int unsigned field_sum(input int first, input int n);
    int unsigned s;
    s = 0;
    for (int i = 0; i < n; i++) begin
      if (frame_bits[first + i]) s += DigitWeight[i];
    end
    return s;
  endfunction

  // Decode the stored frame; loads fields in check order up to the first bad one.
  function automatic bit load_frame();
    int unsigned mi, hr, dy, wd, mo, yr;
    mi = field_sum(21, 7);
    hr = field_sum(29, 6);
    dy = field_sum(36, 6);
    wd = field_sum(42, 3);
    mo = field_sum(45, 5);
    yr = field_sum(50, 8);
    sec_r = 0;
    if (hr > 23) return 1'b0;
    hour_r = hr;
    if (mi > 59) return 1'b0;
    min_r = mi;
    if (dy < 1 || dy > 31) return 1'b0;
    day_r = dy;
    if (wd < 1 || wd > 7) return 1'b0;
    wday_r = wd;
    if (mo < 1 || mo > 12) return 1'b0;
    month_r = mo;
    if (yr > 99) return 1'b0;
    year_r = yr;
    return 1'b1;
  endfunction

  function automatic result_t decode_tick(input logic level);
    result_t r;
    logic    mark, done, ok;
    mark = 1'b0;
    done = 1'b0;
    ok   = 1'b0;
    // Search mode tracks unbroken runs; sync mode just counts per second.
    if (level) begin
      if (high_run != '1) high_run++;
      if (!sync_on) low_run = '0;
    end else begin
      if (low_run != '1) low_run++;
      if (!sync_on) high_run = '0;
    end
    tick_cnt = tick_cnt + 8'd1;
    if (tick_cnt >= cfg_tps) begin
      tick_cnt = '0;
      mark     = 1'b1;
      sec_r    = (sec_r + 1) & 6'h3F;
      if (!sync_on) begin
        if (high_run > cfg_marker) begin
          // Minute gap seen: start at bit 0, calendar skips this second.
          bit_idx  = '0;
          high_run = '0;
          low_run  = '0;
          sync_on  = 1'b1;
        end else begin
          carry_calendar();
        end
      end else begin
        // Too little low time leaves the stored bit untouched.
        if (low_run > cfg_zero_min && low_run <= cfg_one_min) frame_bits[bit_idx] = 1'b0;
        else if (low_run > cfg_one_min) frame_bits[bit_idx] = 1'b1;
        high_run = '0;
        low_run  = '0;
        bit_idx  = bit_idx + 6'd1;
        if (bit_idx > FrameLast) begin
          bit_idx = '0;
          carry_calendar();
          ok   = load_frame();
          done = 1'b1;
          if (!ok) sync_on = 1'b0;
        end
        carry_calendar();
      end
    end
    r.second_mark  = mark;
    r.in_sync      = sync_on;
    r.frame_done   = done;
    r.frame_valid  = done & ok;
    r.seconds      = sec_r[5:0];
    r.minutes      = min_r[5:0];
    r.hours        = hour_r[4:0];
    r.day_of_month = day_r[4:0];
    r.month_num    = month_r[3:0];
    r.year_num     = year_r[7:0];
    r.weekday_num  = wday_r[2:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, timeout
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Far beyond the slowest legal run (a few thousand beats).
  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Drivers. Inputs move on the falling edge, handshakes are seen on the rising.
  // ---------------------------------------------------------------------------

  // One sample tick; expectation is queued at the edge the beat is taken.
  task automatic send_tick(input logic level);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    @(negedge clk_i);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= in_beat_t'(level);
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    tick_results_q.push_back(decode_tick(level));
    ticks_sent++;
  endtask

  // Stop sending and hold off until every queued result has been checked.
  task automatic wait_drained();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (tick_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgWidth-1:0] val);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= cfg_beat_t'{reg_index: idx, wdata: val};
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    case (idx)
      CfgTicksPerSec: cfg_tps      = val;
      CfgMarkerTicks: cfg_marker   = val;
      CfgZeroLowMin:  cfg_zero_min = val;
      CfgOneLowMin:   cfg_one_min  = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // Registers change only with the pipe empty.
  task automatic load_settings(input int tps, input int marker, input int zero_min,
                               input int one_min);
    wait_drained();
    write_reg(CfgTicksPerSec, tps[7:0]);
    write_reg(CfgMarkerTicks, marker[7:0]);
    write_reg(CfgZeroLowMin, zero_min[7:0]);
    write_reg(CfgOneLowMin, one_min[7:0]);
  endtask

  // Rest of the current second, low time chosen to land in the wanted class.
  // Falls back to any low count when the thresholds leave the class empty.
  task automatic send_second(input sec_kind_e kind);
    int rem, lo, hi, lows, i;
    rem = (tick_cnt < cfg_tps) ? cfg_tps - tick_cnt : 1;
    case (kind)
      BitOne: begin
        lo = cfg_one_min + 1;
        hi = rem;
      end
      BitZero: begin
        lo = cfg_zero_min + 1;
        hi = (cfg_one_min < rem) ? cfg_one_min : rem;
      end
      default: begin
        lo = 0;
        hi = (cfg_zero_min < rem) ? cfg_zero_min : rem;
      end
    endcase
    lows = (lo <= hi) ? $urandom_range(hi, lo) : $urandom_range(rem, 0);
    for (i = 0; i < rem; i++) send_tick(i < lows ? 1'b0 : 1'b1);
  endtask

  // High carrier until the decoder locks on a minute gap (bounded).
  task automatic send_marker();
    int n;
    n = 0;
    while (!sync_on && n < 600) begin
      send_tick(1'b1);
      n++;
    end
  endtask

  task automatic send_search_seconds(input int n);
    repeat (n * cfg_tps) send_tick(1'b0);
  endtask

  function automatic logic [7:0] bcd(input int v);
    return 8'((v / 10) * 16 + (v % 10));
  endfunction

  // Frame with random filler; time fields placed at their bit positions.
  function automatic logic [58:0] build_frame(input logic [7:0] mi_c, input logic [7:0] hr_c,
                                              input logic [7:0] dy_c, input logic [7:0] wd_c,
                                              input logic [7:0] mo_c, input logic [7:0] yr_c);
    logic [58:0] f;
    f = {$urandom, $urandom};
    f[21 +: 7] = mi_c[6:0];
    f[29 +: 6] = hr_c[5:0];
    f[36 +: 6] = dy_c[5:0];
    f[42 +: 3] = wd_c[2:0];
    f[45 +: 5] = mo_c[4:0];
    f[50 +: 8] = yr_c;
    return f;
  endfunction

  // Sends the frame from the decoder's current bit on; keep_pct of the
  // seconds get too little low time, so the old bit stays.
  task automatic send_frame(input logic [58:0] f, input int keep_pct);
    int start, i;
    start = bit_idx;
    for (i = start; i <= FrameLast; i++) begin
      if ($urandom_range(0, 99) < keep_pct) send_second(BitKeep);
      else send_second(f[i] ? BitOne : BitZero);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: one result beat per tick, compared against the oldest
  // expectation field by field. Ready drops for a random stall before each beat unless no_idle is set.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (got_v !== want_v) begin
      err_cnt++;
      // Cap the log; the verdict still counts every mismatch.
      if (err_cnt <= 200)
        $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want_v, got_v);
    end
  endtask

  initial begin : result_checker
    result_t got, want;
    int      stall;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        @(negedge clk_i);
        out_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
      got = out_ch.data;
      if (tick_results_q.size() == 0) begin
        err_cnt++;
        $display("%0t ns: result beat with nothing expected, expected none actual %h",
                 $time, got);
      end else begin
        want = tick_results_q.pop_front();
        check_field("second_mark", want.second_mark, got.second_mark);
        check_field("in_sync", want.in_sync, got.in_sync);
        check_field("frame_done", want.frame_done, got.frame_done);
        check_field("frame_valid", want.frame_valid, got.frame_valid);
        check_field("seconds", want.seconds, got.seconds);
        check_field("minutes", want.minutes, got.minutes);
        check_field("hours", want.hours, got.hours);
        check_field("day_of_month", want.day_of_month, got.day_of_month);
        check_field("month_num", want.month_num, got.month_num);
        check_field("year_num", want.year_num, got.year_num);
        check_field("weekday_num", want.weekday_num, got.weekday_num);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset clock is visible; tick settings below 2 close a second on every
  // tick, so ~66 ticks roll 23:59 on 31.12. into the new year.
  task automatic test_reset_and_tick_floor();
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    load_settings(0, RstMarkerTicks, RstZeroLowMin, RstOneLowMin);
    repeat (30) send_tick(1'b0);
    load_settings(1, 254, RstZeroLowMin, RstOneLowMin);
    repeat (36) send_tick(1'b0);
  endtask

  // Widest second: the high run saturates at all ones and still beats a
  // marker threshold of 254; a saturated low run gives a one bit.
  // The frame is then finished at the fastest rate with a bad hour, which
  // loads nothing and drops back to search.
  task automatic test_register_extremes();
    load_settings(255, 254, 254, 254);
    send_marker();
    send_second(BitOne);
    send_second(BitKeep);
    load_settings(2, 1, 0, 1);
    send_frame(build_frame(bcd(30), 8'h3F, bcd(1), 8'd1, bcd(1), bcd(0)), 0);
  endtask

  task automatic test_frame_decode();
    load_settings(2, 3, 0, 1);
    send_marker();
    send_frame(build_frame(bcd(34), bcd(12), bcd(15), 8'd3, bcd(6), bcd(25)), 0);
    // Every second too short: old bits stay, same time decodes again.
    send_frame(build_frame(bcd(7), bcd(7), bcd(7), 8'd7, bcd(7), bcd(7)), 100);
    // Bad year after 23:59 on 31 Feb: earlier fields load, then a minute of
    // search mode carries the day past the month end.
    send_frame(build_frame(bcd(59), bcd(23), bcd(31), 8'd7, bcd(2), 8'hA5), 0);
    send_search_seconds(61);
    // Same at New Year's Eve: carries into January and the next year.
    send_marker();
    send_frame(build_frame(bcd(59), bcd(23), bcd(31), 8'd7, bcd(12), 8'hFF), 0);
    send_search_seconds(61);
    // Hour fails first: nothing loads.
    send_marker();
    send_frame(build_frame(bcd(0), 8'h3F, bcd(1), 8'd1, bcd(1), bcd(1)), 0);
  endtask

  // zero_low_min not below one_low_min: no zero bit can ever be written.
  task automatic test_threshold_overlap();
    load_settings(3, 4, 1, 1);
    send_marker();
    send_frame(build_frame(bcd(45), bcd(6), bcd(20), 8'd5, bcd(11), bcd(99)), 0);
    load_settings(2, 3, 0, 0);
    send_marker();
    send_frame(build_frame(bcd(1), bcd(2), bcd(3), 8'd4, bcd(5), bcd(6)), 0);
  endtask

  task automatic pick_random_setting();
    int t, m, z, o;
    t = ($urandom_range(0, 3) == 0) ? 4 : $urandom_range(3, 2);
    o = $urandom_range(t - 1, 1);
    z = $urandom_range(o - 1, 0);
    if ($urandom_range(0, 7) == 0) z = o;
    m = $urandom_range(3 * t, 1);
    load_settings(t, m, z, o);
  endtask

  // Mostly well-formed minutes with random content; some fields corrupted,
  // some bits left short, plus noise and stretches of plain search mode.
  task automatic send_random_frame();
    int         mi, hr, dy, wd, mo, yr;
    logic [7:0] codes [0:5];
    mi = $urandom_range(59, 0);
    hr = $urandom_range(23, 0);
    dy = $urandom_range(31, 1);
    wd = $urandom_range(7, 1);
    mo = $urandom_range(12, 1);
    yr = $urandom_range(99, 0);
    // Lean toward the rollover corners.
    if ($urandom_range(0, 3) == 0) begin
      mi = 59;
      hr = 23;
      dy = ($urandom_range(0, 1) == 0) ? 31 : 28;
      mo = ($urandom_range(0, 1) == 0) ? 12 : 2;
    end
    codes[0] = bcd(mi);
    codes[1] = bcd(hr);
    codes[2] = bcd(dy);
    codes[3] = bcd(wd);
    codes[4] = bcd(mo);
    codes[5] = bcd(yr);
    if ($urandom_range(0, 4) == 0) codes[$urandom_range(5, 0)] = $urandom;
    send_frame(build_frame(codes[0], codes[1], codes[2], codes[3], codes[4], codes[5]),
               ($urandom_range(0, 3) == 0) ? 10 : 0);
  endtask

  task automatic test_random_traffic();
    int unsigned first;
    first = ticks_sent;
    while (ticks_sent - first < RandomTicks) begin
      no_idle = ($urandom_range(0, 3) == 0);
      if (!sync_on && $urandom_range(0, 2) == 0) pick_random_setting();
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(30, 3)) send_tick($urandom_range(1, 0));
        1: if (!sync_on) send_search_seconds($urandom_range(62, 1));
        default: begin
          send_marker();
          send_random_frame();
        end
      endcase
    end
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni       = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    no_idle      = 1'b0;
    ticks_sent   = 0;
    err_cnt      = 0;
    model_reset();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_and_tick_floor();
    test_register_extremes();
    test_frame_decode();
    test_threshold_overlap();
    test_random_traffic();

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
